// ----- sv/pis_pkg.sv -----
// ----------------------------------------------------------------------------
// pis_pkg
// Shared codes and types for the playback index sequencer: play modes,
// command codes, register indexes and the flag groups passed between blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package pis_pkg;

    localparam int CMD_WIDTH  = 3;
    localparam int MODE_WIDTH = 3;
    localparam int CFG_WIDTH  = 16;
    localparam int CFG_IDX_WIDTH = 2;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_ONCE    = 3'd0,
        MODE_LOOP    = 3'd1,
        MODE_REFLECT = 3'd2,
        MODE_CLAMP   = 3'd3,
        MODE_ADVANCE = 3'd4
    } t_mode;

    localparam logic [CMD_WIDTH-1:0] CMD_UPDATE    = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_STEP      = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_STEP_BACK = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_PLAY      = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_REWIND    = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_FAST_FWD  = 3'd5;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RANGE_START = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RANGE_END   = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PLAY_MODE   = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_AMOUNT = 2'd3;

    localparam logic [MODE_WIDTH-1:0] MODE_RESET = 3'd1;
    localparam logic [CFG_WIDTH-1:0]  STEP_RESET = 16'd1;

    typedef struct packed {
        logic dir_down;
        logic stop;
    } t_adv_flags;

    typedef struct packed {
        logic sent;
        logic stop;
        logic playing;
        logic dir_down;
    } t_step_flags;

endpackage

`default_nettype wire

// ----- sv/pis_advance.sv -----
// ----------------------------------------------------------------------------
// pis_advance
// One sequencing step of the index inside [lower, upper]: wrap, reflect or
// clamp at the edges depending on the play mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_advance #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire [INDEX_WIDTH-1:0]        i_from,
    input  wire [INDEX_WIDTH-1:0]        i_lower,
    input  wire [INDEX_WIDTH-1:0]        i_upper,
    input  wire [pis_pkg::CFG_WIDTH-1:0] i_step,
    input  pis_pkg::t_mode               i_mode,
    input  wire                          i_dir_down,
    output logic [INDEX_WIDTH-1:0]       o_index,
    output pis_pkg::t_adv_flags          o_flags
);

    localparam int EW = ((INDEX_WIDTH > pis_pkg::CFG_WIDTH) ?
                         INDEX_WIDTH : pis_pkg::CFG_WIDTH) + 1;

    logic [EW-1:0] from_e;
    logic [EW-1:0] lower_e;
    logic [EW-1:0] upper_e;
    logic [EW-1:0] step_e;
    logic [EW-1:0] span_e;
    logic [EW-1:0] amt_a;
    logic [EW-1:0] amt_b;
    logic [EW-1:0] amt;
    logic [EW-1:0] sum_up;
    logic [EW-1:0] lim_dn;
    logic          over;
    logic          under;
    logic          is_once;

    assign from_e  = EW'(i_from);
    assign lower_e = EW'(i_lower);
    assign upper_e = EW'(i_upper);
    assign step_e  = EW'(i_step);
    assign span_e  = upper_e - lower_e;
    assign is_once = (i_mode == pis_pkg::MODE_ONCE);

    // step limited to upper, and to the range width when reflecting
    assign amt_a = (step_e > upper_e) ? upper_e : step_e;
    assign amt_b = ((i_mode == pis_pkg::MODE_REFLECT) && (amt_a > span_e)) ? span_e : amt_a;
    assign amt   = (amt_b == '0) ? EW'(1) : amt_b;

    assign sum_up = from_e + amt;
    assign lim_dn = lower_e + amt;
    assign over   = !i_dir_down && (sum_up > upper_e);
    assign under  = i_dir_down && (from_e < lim_dn);

    always_comb begin
        o_index          = i_dir_down ? INDEX_WIDTH'(from_e - amt) : INDEX_WIDTH'(sum_up);
        o_flags.dir_down = i_dir_down;
        o_flags.stop     = 1'b0;
        priority if (i_lower == i_upper) begin
            o_index      = i_upper;
            o_flags.stop = is_once;
        end else if (over) begin
            if (i_mode == pis_pkg::MODE_REFLECT) begin
                o_flags.dir_down = !i_dir_down;
                o_index          = INDEX_WIDTH'(upper_e - amt);
            end else if (i_mode == pis_pkg::MODE_CLAMP) begin
                o_flags.dir_down = !i_dir_down;
                o_index          = i_upper;
            end else begin
                o_flags.stop = is_once;
                o_index      = i_lower;
            end
        end else if (under) begin
            if (i_mode == pis_pkg::MODE_REFLECT) begin
                o_flags.dir_down = !i_dir_down;
                o_index          = INDEX_WIDTH'(lim_dn);
            end else if (i_mode == pis_pkg::MODE_CLAMP) begin
                o_flags.dir_down = !i_dir_down;
                o_index          = i_lower;
            end else begin
                o_flags.stop = is_once;
                o_index      = i_upper;
            end
        end else begin
            o_flags.stop = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pis_step.sv -----
// ----------------------------------------------------------------------------
// pis_step
// Command decode for one request: range check of the stored index, choice
// of the start point and direction, one shared step unit, and the new state.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_step #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire [INDEX_WIDTH-1:0]         i_range_start,
    input  wire [INDEX_WIDTH-1:0]         i_range_end,
    input  wire [pis_pkg::MODE_WIDTH-1:0] i_play_mode,
    input  wire [pis_pkg::CFG_WIDTH-1:0]  i_step_amount,
    input  wire [INDEX_WIDTH-1:0]         i_cur_index,
    input  wire                           i_dir_down,
    input  wire                           i_playing,
    input  wire [pis_pkg::CMD_WIDTH-1:0]  i_command,
    input  wire                           i_override_valid,
    input  wire [INDEX_WIDTH-1:0]         i_override_index,
    output logic [INDEX_WIDTH-1:0]        o_selected,
    output logic [INDEX_WIDTH-1:0]        o_next,
    output pis_pkg::t_step_flags          o_flags
);

    pis_pkg::t_mode      mode;
    pis_pkg::t_adv_flags adv_flags;
    logic [INDEX_WIDTH-1:0] lower;
    logic [INDEX_WIDTH-1:0] upper;
    logic [INDEX_WIDTH-1:0] cur0;
    logic [INDEX_WIDTH-1:0] base;
    logic [INDEX_WIDTH-1:0] adv_from;
    logic [INDEX_WIDTH-1:0] adv_index;
    logic                   reversed;
    logic                   dir0;
    logic                   adv_dir;
    logic                   out_of_range;

    assign mode = (i_play_mode > pis_pkg::MODE_ADVANCE) ? pis_pkg::MODE_LOOP
                                                        : pis_pkg::t_mode'(i_play_mode);

    assign reversed     = i_range_start > i_range_end;
    assign lower        = reversed ? i_range_end : i_range_start;
    assign upper        = reversed ? i_range_start : i_range_end;
    assign out_of_range = (i_cur_index < lower) || (i_cur_index > upper);
    assign cur0         = out_of_range ? i_range_start : i_cur_index;
    assign dir0         = (out_of_range || mode == pis_pkg::MODE_ONCE ||
                           mode == pis_pkg::MODE_LOOP) ? reversed : i_dir_down;

    // start point for play, rewind, fast forward and select
    always_comb begin
        base = cur0;
        if (i_command == pis_pkg::CMD_PLAY) begin
            if (!i_playing && mode == pis_pkg::MODE_ONCE && cur0 >= i_range_end) begin
                base = i_range_start;
            end
        end else if (i_command == pis_pkg::CMD_REWIND) begin
            base = i_range_start;
        end else if (i_command == pis_pkg::CMD_FAST_FWD) begin
            base = i_range_end;
        end
    end

    assign adv_from = (i_command == pis_pkg::CMD_STEP ||
                       i_command == pis_pkg::CMD_STEP_BACK) ? cur0 : base;
    assign adv_dir  = (i_command == pis_pkg::CMD_STEP_BACK) ? !dir0 : dir0;

    pis_advance #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_advance (
        .i_from     (adv_from),
        .i_lower    (lower),
        .i_upper    (upper),
        .i_step     (i_step_amount),
        .i_mode     (mode),
        .i_dir_down (adv_dir),
        .o_index    (adv_index),
        .o_flags    (adv_flags)
    );

    always_comb begin
        o_selected       = cur0;
        o_next           = cur0;
        o_flags.sent     = 1'b1;
        o_flags.stop     = 1'b0;
        o_flags.playing  = i_playing;
        o_flags.dir_down = dir0;
        if (i_override_valid) begin
            o_selected       = i_override_index;
            o_next           = i_override_index;
            o_flags.dir_down = i_dir_down;
        end else begin
            unique case (i_command)
                pis_pkg::CMD_UPDATE: begin
                    o_flags.sent = 1'b0;
                end
                pis_pkg::CMD_STEP: begin
                    o_selected       = adv_index;
                    o_next           = adv_index;
                    o_flags.stop     = adv_flags.stop;
                    o_flags.dir_down = adv_flags.dir_down;
                end
                pis_pkg::CMD_STEP_BACK: begin
                    // direction inverted for this step only
                    o_selected       = adv_index;
                    o_next           = adv_index;
                    o_flags.stop     = adv_flags.stop;
                    o_flags.dir_down = !adv_flags.dir_down;
                end
                pis_pkg::CMD_PLAY: begin
                    o_selected       = base;
                    o_flags.dir_down = adv_flags.dir_down;
                    if (adv_flags.stop) begin
                        o_next          = base;
                        o_flags.stop    = 1'b1;
                        o_flags.playing = 1'b0;
                    end else begin
                        o_next          = adv_index;
                        o_flags.playing = 1'b1;
                    end
                end
                default: begin
                    // rewind, fast forward and plain select
                    o_selected = base;
                    if (mode == pis_pkg::MODE_ADVANCE) begin
                        o_next           = adv_index;
                        o_flags.stop     = adv_flags.stop;
                        o_flags.dir_down = adv_flags.dir_down;
                    end else begin
                        o_next = base;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/playback_index_sequencer.sv -----
// ----------------------------------------------------------------------------
// playback_index_sequencer
// Frame index sequencer for playback: steps a stored index through a
// start/end range in once, loop, reflect, clamp or advance-on-select modes.
// ----------------------------------------------------------------------------
// Each command request gives exactly one result. A request is held in an
// input register, decoded and stepped from there, and written to the result
// register together with the new index, direction and playing state once
// the result register is free or being read. The input register is refilled
// in the same cycle it drains, so throughput is one request per cycle; only
// a stall on the output side holds it back. Registers are written through
// the configuration channel, which is always ready; write them only while
// no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module playback_index_sequencer #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    // command requests
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] override_index
    input  wire  [3:0]  s_axis_tuser,   // [2:0] command, [3] override_valid
    // results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] selected_index, [31:16] next_index
    output logic [1:0]  m_axis_tuser    // [0] selection_sent, [1] stop_request
);

    localparam int FW = 16;

    logic [INDEX_WIDTH-1:0]         r_range_start;
    logic [INDEX_WIDTH-1:0]         r_range_end;
    logic [pis_pkg::MODE_WIDTH-1:0] r_play_mode;
    logic [pis_pkg::CFG_WIDTH-1:0]  r_step_amount;

    logic [INDEX_WIDTH-1:0] r_cur_index;
    logic                   r_dir_down;
    logic                   r_playing;

    logic                          r_in_valid;
    logic [pis_pkg::CMD_WIDTH-1:0] r_in_command;
    logic                          r_in_override;
    logic [INDEX_WIDTH-1:0]        r_in_index;

    logic                   r_out_valid;
    logic [INDEX_WIDTH-1:0] r_out_selected;
    logic [INDEX_WIDTH-1:0] r_out_next;
    logic                   r_out_sent;
    logic                   r_out_stop;

    logic                   advance;
    logic                   in_take;
    logic [INDEX_WIDTH-1:0] n_selected;
    logic [INDEX_WIDTH-1:0] n_next;
    pis_pkg::t_step_flags   n_flags;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= '0;
            r_range_end   <= '0;
            r_play_mode   <= pis_pkg::MODE_RESET;
            r_step_amount <= pis_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pis_pkg::CFG_RANGE_START: r_range_start <= INDEX_WIDTH'(i_cfg_data);
                pis_pkg::CFG_RANGE_END:   r_range_end   <= INDEX_WIDTH'(i_cfg_data);
                pis_pkg::CFG_PLAY_MODE:   r_play_mode   <= i_cfg_data[pis_pkg::MODE_WIDTH-1:0];
                default:                  r_step_amount <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_command  <= s_axis_tuser[pis_pkg::CMD_WIDTH-1:0];
            r_in_override <= s_axis_tuser[pis_pkg::CMD_WIDTH];
            r_in_index    <= INDEX_WIDTH'(s_axis_tdata);
        end
    end

    pis_step #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_step (
        .i_range_start    (r_range_start),
        .i_range_end      (r_range_end),
        .i_play_mode      (r_play_mode),
        .i_step_amount    (r_step_amount),
        .i_cur_index      (r_cur_index),
        .i_dir_down       (r_dir_down),
        .i_playing        (r_playing),
        .i_command        (r_in_command),
        .i_override_valid (r_in_override),
        .i_override_index (r_in_index),
        .o_selected       (n_selected),
        .o_next           (n_next),
        .o_flags          (n_flags)
    );

    // sequencer state moves on with each request that reaches the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_index <= '0;
            r_dir_down  <= 1'b0;
            r_playing   <= 1'b0;
        end else if (advance) begin
            r_cur_index <= n_next;
            r_dir_down  <= n_flags.dir_down;
            r_playing   <= n_flags.playing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_selected <= n_selected;
            r_out_next     <= n_next;
            r_out_sent     <= n_flags.sent;
            r_out_stop     <= n_flags.stop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {FW'(r_out_next), FW'(r_out_selected)};
    assign m_axis_tuser  = {r_out_stop, r_out_sent};

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for playback_index_sequencer. A directed table covers
// the reset state, the range and step extremes, every command and play mode,
// override, reversed and single-index ranges. It is followed by random
// settings with bursts of command requests. Each result is checked against
// a typed table row or the in-bench sequencer model; both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [pis_pkg::CMD_WIDTH-1:0]  CMD_SELECT = 3'd6;
    localparam logic [pis_pkg::CMD_WIDTH-1:0]  CMD_SPARE  = 3'd7;
    localparam logic [pis_pkg::MODE_WIDTH-1:0] MODE_SPARE = 3'd7;
    localparam int ITEM_TARGET = 1650;

    typedef struct packed {
        logic        sent;
        logic [15:0] sel;
        logic        stop;
        logic [15:0] nxt;
    } t_sel_result;

    typedef struct packed {
        logic                              is_cfg;
        logic [pis_pkg::CFG_IDX_WIDTH-1:0] reg_idx;
        logic [15:0]                       cfg_val;
        logic [pis_pkg::CMD_WIDTH-1:0]     cmd;
        logic                              ov;
        logic [15:0]                       oidx;
        logic                              typed;
        t_sel_result                       want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] override_index
    logic [3:0]  s_axis_tuser;   // [2:0] command, [3] override_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] selected_index, [31:16] next_index
    logic [1:0]  m_axis_tuser;   // [0] selection_sent, [1] stop_request

    playback_index_sequencer #(.INDEX_WIDTH(16)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // sequencer model state
    logic [15:0]                    cfg_start;
    logic [15:0]                    cfg_end;
    logic [pis_pkg::MODE_WIDTH-1:0] cfg_mode;
    logic [15:0]                    cfg_step;
    logic [15:0]                    idx_cur;
    bit                             dir_dn;
    bit                             is_playing;

    t_sel_result sel_expect_q[$];
    t_row        dir_table[$];

    int err_count;
    int cmd_count;
    int result_count;
    int cfg_count;
    int setting_count;
    int stop_count;
    logic [15:0] rx_cycle;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // index sequencer model
    // ------------------------------------------------------------------------
    function automatic logic [pis_pkg::MODE_WIDTH-1:0] mode_eff();
        return (cfg_mode > pis_pkg::MODE_ADVANCE) ? pis_pkg::MODE_LOOP : cfg_mode;
    endfunction

    task automatic seq_advance(input logic [15:0] from, input logic [15:0] lower,
                               input logic [15:0] upper, inout bit stop,
                               output logic [15:0] res);
        int lo;
        int up;
        int amt;
        int pos;
        logic [pis_pkg::MODE_WIDTH-1:0] m;
        lo = lower;
        up = upper;
        m = mode_eff();
        if (up == lo) begin
            if (m == pis_pkg::MODE_ONCE)
                stop = 1'b1;
            res = upper;
        end else begin
            amt = cfg_step;
            if (amt > up)
                amt = up;
            // reflection must land inside the range
            if (m == pis_pkg::MODE_REFLECT && amt > up - lo)
                amt = up - lo;
            if (amt < 1)
                amt = 1;
            pos = dir_dn ? int'(from) - amt : int'(from) + amt;
            if (pos > up) begin
                if (m == pis_pkg::MODE_REFLECT) begin
                    dir_dn = !dir_dn;
                    res = 16'(up - amt);
                end else if (m == pis_pkg::MODE_CLAMP) begin
                    dir_dn = !dir_dn;
                    res = upper;
                end else begin
                    if (m == pis_pkg::MODE_ONCE)
                        stop = 1'b1;
                    res = lower;
                end
            end else if (pos < lo) begin
                if (m == pis_pkg::MODE_REFLECT) begin
                    dir_dn = !dir_dn;
                    res = 16'(lo + amt);
                end else if (m == pis_pkg::MODE_CLAMP) begin
                    dir_dn = !dir_dn;
                    res = lower;
                end else begin
                    if (m == pis_pkg::MODE_ONCE)
                        stop = 1'b1;
                    res = upper;
                end
            end else begin
                res = 16'(pos);
            end
        end
    endtask

    task automatic predict_selection(input logic [pis_pkg::CMD_WIDTH-1:0] cmd,
                                     input logic ov, input logic [15:0] oidx,
                                     output t_sel_result r);
        logic [15:0] lower;
        logic [15:0] upper;
        logic [15:0] which;
        logic [15:0] nxt;
        logic [pis_pkg::MODE_WIDTH-1:0] m;
        bit stop;
        bit play_stop;
        stop = 1'b0;
        play_stop = 1'b0;
        r = '0;
        if (ov) begin
            r.sent = 1'b1;
            r.sel = oidx;
            idx_cur = oidx;
        end else begin
            lower = (cfg_start < cfg_end) ? cfg_start : cfg_end;
            upper = (cfg_start < cfg_end) ? cfg_end : cfg_start;
            m = mode_eff();
            if (m == pis_pkg::MODE_ONCE || m == pis_pkg::MODE_LOOP)
                dir_dn = cfg_start > cfg_end;
            if (idx_cur < lower || idx_cur > upper) begin
                idx_cur = cfg_start;
                dir_dn = cfg_start > cfg_end;
            end
            which = idx_cur;
            case (cmd)
                pis_pkg::CMD_UPDATE: begin
                    r.sel = which;
                end
                pis_pkg::CMD_STEP: begin
                    seq_advance(idx_cur, lower, upper, stop, which);
                    r.sent = 1'b1;
                    r.sel = which;
                end
                pis_pkg::CMD_STEP_BACK: begin
                    dir_dn = !dir_dn;
                    seq_advance(idx_cur, lower, upper, stop, which);
                    dir_dn = !dir_dn;
                    r.sent = 1'b1;
                    r.sel = which;
                end
                pis_pkg::CMD_PLAY: begin
                    // once mode restarts from range start when not running
                    if (!is_playing && m == pis_pkg::MODE_ONCE && which >= cfg_end)
                        which = cfg_start;
                    r.sent = 1'b1;
                    r.sel = which;
                    seq_advance(which, lower, upper, play_stop, nxt);
                    if (play_stop) begin
                        stop = 1'b1;
                        is_playing = 1'b0;
                    end else begin
                        is_playing = 1'b1;
                        which = nxt;
                    end
                end
                default: begin
                    if (cmd == pis_pkg::CMD_REWIND)
                        which = cfg_start;
                    else if (cmd == pis_pkg::CMD_FAST_FWD)
                        which = cfg_end;
                    r.sent = 1'b1;
                    r.sel = which;
                    if (m == pis_pkg::MODE_ADVANCE)
                        seq_advance(which, lower, upper, stop, which);
                end
            endcase
            idx_cur = which;
        end
        r.stop = stop;
        r.nxt = idx_cur;
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // valid is left high so that back-to-back writes need no lowering
    task automatic cfg_write(input logic [pis_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            pis_pkg::CFG_RANGE_START: cfg_start = d;
            pis_pkg::CFG_RANGE_END:   cfg_end = d;
            pis_pkg::CFG_PLAY_MODE:   cfg_mode = d[pis_pkg::MODE_WIDTH-1:0];
            default:                  cfg_step = d;
        endcase
        cfg_count++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sel_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic issue_cmd(input logic [pis_pkg::CMD_WIDTH-1:0] cmd, input logic ov,
                             input logic [15:0] oidx, input logic typed,
                             input t_sel_result want);
        t_sel_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {ov, cmd};
        s_axis_tdata <= oidx;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_selection(cmd, ov, oidx, r);
        sel_expect_q.push_back(typed ? want : r);
        cmd_count++;
    endtask

    function automatic t_row row_cfg(input logic [pis_pkg::CFG_IDX_WIDTH-1:0] idx,
                                     input logic [15:0] d);
        t_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.cfg_val = d;
        return row;
    endfunction

    function automatic t_row row_req(input logic [pis_pkg::CMD_WIDTH-1:0] cmd,
                                     input logic ov,
                                     input logic [15:0] oidx, input logic typed,
                                     input logic sent, input logic [15:0] sel,
                                     input logic stop, input logic [15:0] nxt);
        t_row row;
        row = '0;
        row.cmd = cmd;
        row.ov = ov;
        row.oidx = oidx;
        row.typed = typed;
        row.want = '{sent: sent, sel: sel, stop: stop, nxt: nxt};
        return row;
    endfunction

    task automatic pick_setting(input bit write_all);
        int kind;
        int base;
        int other;
        logic [15:0] d;
        if (write_all || $urandom_range(0, 1) == 1) begin
            kind = $urandom_range(0, 9);
            base = $urandom_range(0, 65535);
            case (kind)
                0: begin base = 0; other = 65535; end
                1: begin base = 65535; other = 0; end
                2: other = base;
                3: other = $urandom_range(0, 65535);
                default: begin
                    // narrow range so that edges are hit often
                    other = ($urandom_range(0, 1) == 1) ? base + $urandom_range(1, 12)
                                                        : base - $urandom_range(1, 12);
                    if (other > 65535)
                        other = 65535;
                    if (other < 0)
                        other = 0;
                end
            endcase
            cfg_write(pis_pkg::CFG_RANGE_START, 16'(base));
            cfg_write(pis_pkg::CFG_RANGE_END, 16'(other));
        end
        if (write_all || $urandom_range(0, 1) == 1) begin
            d = 16'($urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0)
                d[15:pis_pkg::MODE_WIDTH] = 13'($urandom);
            cfg_write(pis_pkg::CFG_PLAY_MODE, d);
        end
        if (write_all || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 7))
                0: d = 16'd0;
                1: d = 16'hFFFF;
                2: d = 16'($urandom);
                default: d = 16'($urandom_range(1, 5));
            endcase
            cfg_write(pis_pkg::CFG_STEP_AMOUNT, d);
        end
        setting_count++;
    endtask

    // ------------------------------------------------------------------------
    // result side: stall pattern and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_cycle      <= '0;
            m_axis_tready <= 1'b1;
        end else begin
            rx_cycle <= rx_cycle + 16'd1;
            case (rx_cycle[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= (rx_cycle[1:0] != 2'd0);
                default: m_axis_tready <= (rx_cycle[4:0] < 5'd5);
            endcase
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_sel_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (sel_expect_q.size() == 0) begin
                $display("%0t ns: result with none expected, actual sel %0h next %0h",
                         $time, m_axis_tdata[15:0], m_axis_tdata[31:16]);
                err_count++;
            end else begin
                want = sel_expect_q.pop_front();
                if (want.stop)
                    stop_count++;
                if (m_axis_tuser[0] !== want.sent)
                    report_field("selection_sent", want.sent, m_axis_tuser[0]);
                if (m_axis_tdata[15:0] !== want.sel)
                    report_field("selected_index", want.sel, m_axis_tdata[15:0]);
                if (m_axis_tuser[1] !== want.stop)
                    report_field("stop_request", want.stop, m_axis_tuser[1]);
                if (m_axis_tdata[31:16] !== want.nxt)
                    report_field("next_index", want.nxt, m_axis_tdata[31:16]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_row row;
        int burst_left;
        int gap;
        int guard;
        int lo;
        int up;
        int pick;
        logic [pis_pkg::CMD_WIDTH-1:0] cmd;
        logic ov;
        logic [15:0] oidx;

        err_count = 0;
        cmd_count = 0;
        result_count = 0;
        cfg_count = 0;
        setting_count = 0;
        stop_count = 0;
        cfg_start = '0;
        cfg_end = '0;
        cfg_mode = pis_pkg::MODE_RESET;
        cfg_step = pis_pkg::STEP_RESET;
        idx_cur = '0;
        dir_dn = 1'b0;
        is_playing = 1'b0;

        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset state, single-index range
        dir_table.push_back(row_req(pis_pkg::CMD_UPDATE, 1'b0, 16'h0000,
                                    1, 0, 16'h0000, 0, 16'h0000));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b1, 16'hFFFF,
                                    1, 1, 16'hFFFF, 0, 16'hFFFF));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h1234,
                                    1, 1, 16'h0000, 0, 16'h0000));
        dir_table.push_back(row_cfg(pis_pkg::CFG_PLAY_MODE, 16'(pis_pkg::MODE_ONCE)));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000,
                                    1, 1, 16'h0000, 1, 16'h0000));
        // full range, largest step
        dir_table.push_back(row_cfg(pis_pkg::CFG_RANGE_END, 16'hFFFF));
        dir_table.push_back(row_cfg(pis_pkg::CFG_STEP_AMOUNT, 16'hFFFF));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000,
                                    1, 1, 16'hFFFF, 0, 16'hFFFF));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000,
                                    1, 1, 16'h0000, 1, 16'h0000));
        dir_table.push_back(row_req(pis_pkg::CMD_PLAY, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_PLAY, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_PLAY, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        // reversed full range, zero step
        dir_table.push_back(row_cfg(pis_pkg::CFG_RANGE_START, 16'hFFFF));
        dir_table.push_back(row_cfg(pis_pkg::CFG_RANGE_END, 16'h0000));
        dir_table.push_back(row_cfg(pis_pkg::CFG_STEP_AMOUNT, 16'h0000));
        dir_table.push_back(row_cfg(pis_pkg::CFG_PLAY_MODE, 16'(pis_pkg::MODE_LOOP)));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP_BACK, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_REWIND, 1'b0, 16'h0000,
                                    1, 1, 16'hFFFF, 0, 16'hFFFF));
        dir_table.push_back(row_req(pis_pkg::CMD_FAST_FWD, 1'b0, 16'h0000,
                                    1, 1, 16'h0000, 0, 16'h0000));
        dir_table.push_back(row_req(CMD_SELECT, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(CMD_SPARE, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        // step larger than the range width in the bounce modes
        dir_table.push_back(row_cfg(pis_pkg::CFG_RANGE_START, 16'd10));
        dir_table.push_back(row_cfg(pis_pkg::CFG_RANGE_END, 16'd20));
        dir_table.push_back(row_cfg(pis_pkg::CFG_STEP_AMOUNT, 16'd100));
        dir_table.push_back(row_cfg(pis_pkg::CFG_PLAY_MODE, 16'(pis_pkg::MODE_REFLECT)));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP_BACK, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_PLAY, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_cfg(pis_pkg::CFG_PLAY_MODE, 16'(pis_pkg::MODE_CLAMP)));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_PLAY, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_cfg(pis_pkg::CFG_PLAY_MODE, 16'(pis_pkg::MODE_ADVANCE)));
        dir_table.push_back(row_req(pis_pkg::CMD_REWIND, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_FAST_FWD, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(CMD_SELECT, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        // spare mode runs as loop; override stores an index outside the range
        dir_table.push_back(row_cfg(pis_pkg::CFG_PLAY_MODE, 16'(MODE_SPARE)));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        dir_table.push_back(row_req(pis_pkg::CMD_UPDATE, 1'b1, 16'h0000,
                                    1, 1, 16'h0000, 0, 16'h0000));
        dir_table.push_back(row_req(pis_pkg::CMD_STEP, 1'b0, 16'h0000, 0, 0, 0, 0, 0));

        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.is_cfg) begin
                wait_idle();
                cfg_write(row.reg_idx, row.cfg_val);
            end else begin
                i_cfg_valid <= 1'b0;
                issue_cmd(row.cmd, row.ov, row.oidx, row.typed, row.want);
            end
        end

        // random settings, each followed by a burst train of requests
        burst_left = $urandom_range(1, 24);
        while (cmd_count < ITEM_TARGET) begin
            wait_idle();
            pick_setting(setting_count == 0);
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(20, 80)) begin
                if (cmd_count >= ITEM_TARGET)
                    break;
                lo = (cfg_start < cfg_end) ? cfg_start : cfg_end;
                up = (cfg_start < cfg_end) ? cfg_end : cfg_start;
                ov = ($urandom_range(0, 9) == 0);
                oidx = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(lo, up))
                                                   : 16'($urandom);
                pick = $urandom_range(0, 15);
                if (pick < 6)
                    cmd = pis_pkg::CMD_PLAY;
                else if (pick < 10)
                    cmd = pis_pkg::CMD_STEP;
                else if (pick < 12)
                    cmd = pis_pkg::CMD_STEP_BACK;
                else if (pick == 12)
                    cmd = pis_pkg::CMD_UPDATE;
                else if (pick == 13)
                    cmd = pis_pkg::CMD_REWIND;
                else if (pick == 14)
                    cmd = pis_pkg::CMD_FAST_FWD;
                else
                    cmd = ($urandom_range(0, 1) == 1) ? CMD_SELECT : CMD_SPARE;
                if (ov)
                    cmd = 3'($urandom_range(0, 7));
                issue_cmd(cmd, ov, oidx, 1'b0, '0);
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (sel_expect_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
        while (sel_expect_q.size() != 0) begin
            row.want = sel_expect_q.pop_front();
            $display("%0t ns: expected result never arrived, sel %0h next %0h",
                     $time, row.want.sel, row.want.nxt);
            err_count++;
        end

        $display("run covered %0d command requests, the directed table and %0d random settings",
                 cmd_count, setting_count);
        $display("%0d register writes, %0d results checked, %0d with a stop request, %0d errors",
                 cfg_count, result_count, stop_count, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("timeout, %0d results still outstanding", sel_expect_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
